### rtl/assert_macros.svh
// Assertion helpers used by the checker file cgrr_checker.sv.
// Both macros sample on the rising edge of clk and are disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CGRR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cgrr assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CGRR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cgrr assertion failed");

`endif

### rtl/cgrr_pkg.sv
package cgrr_pkg;

	// Defaults for the top-level parameters.
	localparam int FontBytesDefault = 2048;
	localparam int MaxGlyphDefault  = 8;

	// Fixed field widths.
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 13;
	localparam int AddrW    = 24;
	localparam int MaskW    = 8;
	localparam int ColorW   = 8;

	// Input item operation codes.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_DRAW = 1'b1;

	// Configuration register indexes.
	typedef enum logic [CfgIdxW-1:0] {
		CFG_CLIP_LEFT,
		CFG_CLIP_TOP,
		CFG_CLIP_RIGHT,
		CFG_CLIP_BOTTOM,
		CFG_LINE_PITCH,
		CFG_DRAW_COLOR,
		CFG_GLYPH_WIDTH,
		CFG_GLYPH_HEIGHT
	} cfg_reg_t;

	// Configuration register file contents.
	typedef struct packed {
		logic [10:0] clip_left;
		logic [10:0] clip_top;
		logic [11:0] clip_right;
		logic [11:0] clip_bottom;
		logic [12:0] line_pitch;
		logic [7:0]  draw_color;
		logic [3:0]  glyph_width;
		logic [3:0]  glyph_height;
	} cfg_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_ROWS
	} seq_state_t;

	// One issued row, waiting for its font bytes.
	typedef struct packed {
		logic             valid;
		logic [2:0]       bit_off;
		logic             row_in;
		logic             underline;
		logic             last;
		logic [AddrW-1:0] addr;
		logic [MaskW-1:0] col_mask;
	} row_ctl_t;

endpackage

### rtl/cgrr_font_mem.sv
module cgrr_font_mem #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr0,
	input  logic [AW-1:0] raddr1,
	output logic [7:0]    rdata0,
	output logic [7:0]    rdata1
);

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rd0_q;
	logic [7:0] rd1_q;

	// Single write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Two registered read ports; the data holds while re is low.
	always_ff @(posedge clk) begin
		if (re) begin
			rd0_q <= mem_q[raddr0];
			rd1_q <= mem_q[raddr1];
		end
	end

	assign rdata0 = rd0_q;
	assign rdata1 = rd1_q;

endmodule

### rtl/cgrr_seq.sv
module cgrr_seq #(
	parameter int FONT_BYTES     = 2048,
	parameter int MAX_GLYPH_SIZE = 8,
	parameter int FA_W           = 11
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cgrr_pkg::cfg_t         cfg,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   opcode,
	input  logic [10:0]            font_addr,
	input  logic [7:0]             font_byte,
	input  logic [7:0]             char_code,
	input  logic signed [11:0]     pos_x,
	input  logic signed [11:0]     pos_y,
	input  logic                   underline,
	input  logic                   en,
	output logic                   mem_we,
	output logic [FA_W-1:0]        mem_waddr,
	output logic [7:0]             mem_wdata,
	output logic [FA_W-1:0]        mem_raddr0,
	output logic [FA_W-1:0]        mem_raddr1,
	output cgrr_pkg::row_ctl_t     row_s1
);

	import cgrr_pkg::*;

	localparam int SzW       = $clog2(MAX_GLYPH_SIZE + 1);
	localparam int BitW      = 8 + $clog2(MAX_GLYPH_SIZE * MAX_GLYPH_SIZE);
	localparam int ByteW     = BitW - 3;
	localparam int WrapW     = (ByteW > 11) ? ByteW : 11;
	localparam int WrapSteps = (WrapW >= FA_W) ? WrapW - FA_W + 1 : 0;

	// Reduce a byte address modulo the store size by restoring subtraction.
	function automatic logic [FA_W-1:0] font_wrap(input logic [WrapW-1:0] v);
		logic [WrapW-1:0] r;
		r = v;
		for (int k = WrapSteps - 1; k >= 0; k--) begin
			if (32'(r) >= (FONT_BYTES << k)) begin
				r = r - WrapW'(FONT_BYTES << k);
			end
		end
		return FA_W'(r);
	endfunction

	// Clamp a glyph dimension to the supported range.
	function automatic logic [SzW-1:0] sat_size(input logic [3:0] v);
		if (v == 4'd0) begin
			return SzW'(1);
		end else if (32'(v) > MAX_GLYPH_SIZE) begin
			return SzW'(MAX_GLYPH_SIZE);
		end else begin
			return SzW'(v);
		end
	endfunction

	seq_state_t state_q;
	seq_state_t state_nxt;

	logic                in_acc;
	logic                draw_acc;
	logic                reject;
	logic                issue;
	logic [SzW-1:0]      w_in;
	logic [SzW-1:0]      h_in;
	logic signed [13:0]  xs;
	logic signed [13:0]  ys;
	logic signed [13:0]  cl;
	logic signed [13:0]  ct;
	logic signed [13:0]  cr;
	logic signed [13:0]  cb;
	logic signed [13:0]  row_pos;
	logic                is_ul;
	logic                last_row;
	logic [FA_W-1:0]     byte0;
	logic [MaskW-1:0]    col_mask;

	logic signed [13:0]  x_q;
	logic signed [13:0]  y_q;
	logic [7:0]          code_q;
	logic                ul_q;
	logic [SzW-1:0]      w_q;
	logic [SzW-1:0]      h_q;
	logic [2*SzW-1:0]    wh_q;
	logic [BitW-1:0]     bit_q;
	logic [AddrW-1:0]    addr_q;
	logic [SzW-1:0]      row_q;
	logic [MaskW-1:0]    col_mask_q;

	assign in_acc   = in_valid && !in_stall;
	assign draw_acc = in_acc && (opcode == OP_DRAW);

	// Loads go straight into the store on the accepting edge.
	assign mem_we    = in_acc && (opcode == OP_LOAD);
	assign mem_waddr = font_wrap(WrapW'(font_addr));
	assign mem_wdata = font_byte;

	// Coarse visibility test on the incoming draw item.
	assign w_in = sat_size(cfg.glyph_width);
	assign h_in = sat_size(cfg.glyph_height);
	assign xs   = {{2{pos_x[11]}}, pos_x};
	assign ys   = {{2{pos_y[11]}}, pos_y};
	assign cl   = $signed(14'(cfg.clip_left));
	assign ct   = $signed(14'(cfg.clip_top));
	assign cr   = $signed(14'(cfg.clip_right));
	assign cb   = $signed(14'(cfg.clip_bottom));
	assign reject = ((xs + $signed(14'(w_in))) < cl) || (xs > cr) ||
		((ys + $signed(14'(h_in))) < ct) || (ys > cb);

	// Per-row decisions for the row being issued.
	assign row_pos  = y_q + $signed(14'(row_q));
	assign is_ul    = (row_q == h_q);
	assign last_row = is_ul || ((row_q == SzW'(h_q - SzW'(1))) && !ul_q);

	// Font bytes holding this row: the one with the first bit and the next.
	assign byte0      = font_wrap(WrapW'(bit_q[BitW-1:3]));
	assign mem_raddr0 = byte0;
	assign mem_raddr1 = (32'(byte0) == FONT_BYTES - 1) ? '0 : FA_W'(byte0 + FA_W'(1));

	// Columns of the glyph that land inside the clip box.
	always_comb begin
		logic signed [13:0] col;
		for (int j = 0; j < MaskW; j++) begin
			col = x_q + 14'(j);
			col_mask[j] = (col >= cl) && (col < cr) && (32'(w_q) > j);
		end
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (draw_acc && !reject) begin
					state_nxt = ST_PREP;
				end
			end
			ST_PREP: begin
				state_nxt = ST_ROWS;
			end
			ST_ROWS: begin
				if (en && last_row) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// State outputs.
	always_comb begin
		in_stall = 1'b1;
		issue    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_PREP: begin
				in_stall = 1'b1;
			end
			ST_ROWS: begin
				issue = en;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Capture the draw item and set up the per-row walk.
	always_ff @(posedge clk) begin
		if (draw_acc) begin
			x_q    <= xs;
			y_q    <= ys;
			code_q <= char_code;
			ul_q   <= underline;
			w_q    <= w_in;
			h_q    <= h_in;
			wh_q   <= (2*SzW)'(w_in) * (2*SzW)'(h_in);
		end
		if (state_q == ST_PREP) begin
			bit_q      <= BitW'(BitW'(code_q) * BitW'(wh_q));
			addr_q     <= AddrW'(AddrW'(cfg.line_pitch) * {{(AddrW-14){y_q[13]}}, y_q})
				+ {{(AddrW-14){x_q[13]}}, x_q};
			row_q      <= '0;
			col_mask_q <= col_mask;
		end else if (issue) begin
			bit_q  <= bit_q + BitW'(w_q);
			addr_q <= addr_q + AddrW'(cfg.line_pitch);
			row_q  <= row_q + SzW'(1);
		end
	end

	// Row control travels alongside the font read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_s1 <= '0;
		end else if (en) begin
			row_s1.valid     <= issue;
			row_s1.bit_off   <= bit_q[2:0];
			row_s1.row_in    <= (row_pos >= ct) && (row_pos < cb);
			row_s1.underline <= is_ul;
			row_s1.last      <= last_row;
			row_s1.addr      <= addr_q;
			row_s1.col_mask  <= col_mask_q;
		end
	end

endmodule

### rtl/cgrr_out.sv
module cgrr_out (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cgrr_pkg::row_ctl_t           row_s1,
	input  logic [7:0]                   rdata0,
	input  logic [7:0]                   rdata1,
	input  logic [cgrr_pkg::ColorW-1:0]  draw_color,
	output logic                         en,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [cgrr_pkg::AddrW-1:0]   row_address,
	output logic [cgrr_pkg::MaskW-1:0]   write_mask,
	output logic [cgrr_pkg::ColorW-1:0]  color,
	output logic                         last
);

	import cgrr_pkg::*;

	logic              valid_q;
	logic [AddrW-1:0]  addr_q;
	logic [MaskW-1:0]  mask_q;
	logic [ColorW-1:0] color_q;
	logic              last_q;
	logic [15:0]       pair;
	logic [MaskW-1:0]  mask;

	// The pipe moves whenever the output register is empty or being taken.
	assign en = !valid_q || !out_stall;

	// Align the glyph row to bit zero and apply the clip.
	assign pair = {rdata1, rdata0} >> row_s1.bit_off;
	always_comb begin
		if (!row_s1.row_in) begin
			mask = '0;
		end else if (row_s1.underline) begin
			mask = row_s1.col_mask;
		end else begin
			mask = pair[MaskW-1:0] & row_s1.col_mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= row_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && row_s1.valid) begin
			addr_q  <= row_s1.addr;
			mask_q  <= mask;
			color_q <= draw_color;
			last_q  <= row_s1.last;
		end
	end

	assign out_valid   = valid_q;
	assign row_address = addr_q;
	assign write_mask  = mask_q;
	assign color       = color_q;
	assign last        = last_q;

endmodule

### rtl/clipped_glyph_row_renderer_top.sv
// Glyph renderer: a load item writes one byte of the font store on its accepting edge and gives
// no result. A draw item that passes the coarse clip test stalls the input through the prep
// state and the row walk, one row per glyph row plus one for an underline row; a rejected draw
// leaves the sequencer idle. The walk issues one glyph row per cycle while the output is not
// stalled, limited by the font store's two read ports (each row needs the byte holding its first
// bit and the next one). Each row write passes the row control register and then the output
// register. Rows outside the clip box still come out with a zero mask. The font store has no
// reset and needs no clearing pass; only bytes that have been loaded may be drawn from.
module clipped_glyph_row_renderer_top #(
	parameter int FONT_BYTES     = cgrr_pkg::FontBytesDefault,
	parameter int MAX_GLYPH_SIZE = cgrr_pkg::MaxGlyphDefault
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [cgrr_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [cgrr_pkg::CfgDataW-1:0]  cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           opcode,
	input  logic [10:0]                    font_addr,
	input  logic [7:0]                     font_byte,
	input  logic [7:0]                     char_code,
	input  logic signed [11:0]             pos_x,
	input  logic signed [11:0]             pos_y,
	input  logic                           underline,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [cgrr_pkg::AddrW-1:0]     row_address,
	output logic [cgrr_pkg::MaskW-1:0]     write_mask,
	output logic [cgrr_pkg::ColorW-1:0]    color,
	output logic                           last
);

	import cgrr_pkg::*;

	localparam int FaW = $clog2(FONT_BYTES);

	cfg_t           cfg_q;
	logic           en;
	logic           mem_we;
	logic [FaW-1:0] mem_waddr;
	logic [7:0]     mem_wdata;
	logic [FaW-1:0] mem_raddr0;
	logic [FaW-1:0] mem_raddr1;
	logic [7:0]     rdata0;
	logic [7:0]     rdata1;
	row_ctl_t       row_s1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clip_left    <= 11'd0;
			cfg_q.clip_top     <= 11'd0;
			cfg_q.clip_right   <= 12'd640;
			cfg_q.clip_bottom  <= 12'd480;
			cfg_q.line_pitch   <= 13'd640;
			cfg_q.draw_color   <= 8'd0;
			cfg_q.glyph_width  <= 4'd8;
			cfg_q.glyph_height <= 4'd8;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				CFG_CLIP_LEFT:    cfg_q.clip_left    <= cfg_data[10:0];
				CFG_CLIP_TOP:     cfg_q.clip_top     <= cfg_data[10:0];
				CFG_CLIP_RIGHT:   cfg_q.clip_right   <= cfg_data[11:0];
				CFG_CLIP_BOTTOM:  cfg_q.clip_bottom  <= cfg_data[11:0];
				CFG_LINE_PITCH:   cfg_q.line_pitch   <= cfg_data[12:0];
				CFG_DRAW_COLOR:   cfg_q.draw_color   <= cfg_data[7:0];
				CFG_GLYPH_WIDTH:  cfg_q.glyph_width  <= cfg_data[3:0];
				CFG_GLYPH_HEIGHT: cfg_q.glyph_height <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	cgrr_seq #(
		.FONT_BYTES     (FONT_BYTES),
		.MAX_GLYPH_SIZE (MAX_GLYPH_SIZE),
		.FA_W           (FaW)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.font_addr  (font_addr),
		.font_byte  (font_byte),
		.char_code  (char_code),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.underline  (underline),
		.en         (en),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr0 (mem_raddr0),
		.mem_raddr1 (mem_raddr1),
		.row_s1     (row_s1)
	);

	cgrr_font_mem #(
		.DEPTH (FONT_BYTES),
		.AW    (FaW)
	) u_font_mem (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.re     (en),
		.raddr0 (mem_raddr0),
		.raddr1 (mem_raddr1),
		.rdata0 (rdata0),
		.rdata1 (rdata1)
	);

	cgrr_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.row_s1      (row_s1),
		.rdata0      (rdata0),
		.rdata1      (rdata1),
		.draw_color  (cfg_q.draw_color),
		.en          (en),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.row_address (row_address),
		.write_mask  (write_mask),
		.color       (color),
		.last        (last)
	);

endmodule

### rtl/cgrr_checker.sv
`include "assert_macros.svh"

module cgrr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          opcode,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [cgrr_pkg::AddrW-1:0]    row_address,
	input logic [cgrr_pkg::MaskW-1:0]    write_mask,
	input logic [cgrr_pkg::ColorW-1:0]   color,
	input logic                          last
);

	import cgrr_pkg::*;

	// A stalled row write stays put.
	`CGRR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(row_address) && $stable(write_mask) && $stable(color) && $stable(last))

	// A font load leaves the sequencer idle, so the input is free in the next cycle.
	`CGRR_ASSERT_NEXT(a_load_one_cycle, in_valid && !in_stall && (opcode == OP_LOAD), !in_stall)

	// A new row write only follows a cycle in which a draw was walking its rows.
	`CGRR_ASSERT_NOW(a_row_from_walk, $rose(out_valid), $past(in_stall, 2))

endmodule

bind clipped_glyph_row_renderer_top cgrr_checker u_checker (.*);

### sim/tb_clipped_glyph_row_renderer_top.sv
`timescale 1ns / 100ps

module tb_clipped_glyph_row_renderer_top;
	import cgrr_pkg::*;

	localparam int StoreBytes   = FontBytesDefault;
	localparam int GlyphMax     = MaxGlyphDefault;
	localparam int ItemTarget   = 430;
	localparam int SettleCycles = 16;
	localparam int CycleLimit   = 400000;

	// One input item as it sits on the input ports.
	typedef struct packed {
		logic        op;
		logic [10:0] addr;
		logic [7:0]  fbyte;
		logic [7:0]  code;
		logic [11:0] x;
		logic [11:0] y;
		logic        ul;
	} glyph_cmd_t;

	// One masked row write as the block should emit it.
	typedef struct packed {
		logic [AddrW-1:0]  addr;
		logic [MaskW-1:0]  mask;
		logic [ColorW-1:0] color;
		logic              last;
	} row_write_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	glyph_cmd_t          on_wire = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [AddrW-1:0]    row_address;
	logic [MaskW-1:0]    write_mask;
	logic [ColorW-1:0]   color;
	logic                last;

	// Shadow copy of the register file, starting at the reset values.
	int         clip_l = 0;
	int         clip_t = 0;
	int         clip_r = 640;
	int         clip_b = 480;
	int         pitch = 640;
	int         ink = 0;
	logic [3:0] gw_reg = 4'd8;
	logic [3:0] gh_reg = 4'd8;

	logic [7:0] font_copy [StoreBytes];
	bit         font_known [StoreBytes];

	glyph_cmd_t pending_items [$];
	row_write_t glyph_rows_q [$];

	int items_made = 0;
	int err_count = 0;
	int cycle_count = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_len = 0;
	int hold_ask = 0;
	int hold_seen = 0;
	int hold_left = 0;
	bit sender_hold = 1'b0;

	clipped_glyph_row_renderer_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (on_wire.op),
		.font_addr  (on_wire.addr),
		.font_byte  (on_wire.fbyte),
		.char_code  (on_wire.code),
		.pos_x      (on_wire.x),
		.pos_y      (on_wire.y),
		.underline  (on_wire.ul),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.row_address(row_address),
		.write_mask (write_mask),
		.color      (color),
		.last       (last)
	);

	always #1 clk = ~clk;

	// Glyph sizes outside 1 .. GlyphMax saturate.
	function automatic int clamp_size(logic [3:0] v);
		if (v == 4'd0)
			return 1;
		if (int'(v) > GlyphMax)
			return GlyphMax;
		return int'(v);
	endfunction

	task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
		err_count++;
		if (err_count <= 100)
			$display("MISMATCH %s: got %h, expected %h", what, got, want);
	endtask

	// Updates the font copy on a load, or appends the row writes a draw should produce.
	task automatic render_glyph(glyph_cmd_t c);
		int x, y, w, h, rows, i, j, row, col, bitpos;
		logic [7:0] m;
		logic in_row;
		row_write_t rw;
		if (c.op == OP_LOAD) begin
			font_copy[c.addr] = c.fbyte;
			return;
		end
		x = int'($signed(c.x));
		y = int'($signed(c.y));
		w = clamp_size(gw_reg);
		h = clamp_size(gh_reg);
		// A glyph box that does not touch the clip box produces nothing.
		if (x + w < clip_l || x > clip_r || y + h < clip_t || y > clip_b)
			return;
		rows = h + int'(c.ul);
		for (i = 0; i < rows; i++) begin
			row = y + i;
			in_row = row >= clip_t && row < clip_b;
			m = '0;
			// The underline row sets every visible column; glyph rows take font bits.
			for (j = 0; j < w; j++) begin
				col = x + j;
				bitpos = int'(c.code) * w * h + i * w + j;
				if (in_row && col >= clip_l && col < clip_r &&
						(i == h || font_copy[(bitpos >> 3) % StoreBytes][bitpos & 7]))
					m[j] = 1'b1;
			end
			rw.addr = 24'(pitch * row + x);
			rw.mask = m;
			rw.color = ink[7:0];
			rw.last = (i == rows - 1);
			glyph_rows_q.push_back(rw);
		end
	endtask

	task automatic queue_load(int addr, int data);
		glyph_cmd_t c;
		c = '0;
		c.op = OP_LOAD;
		c.addr = addr[10:0];
		c.fbyte = data[7:0];
		c.code = 8'($urandom_range(255));
		c.x = 12'($urandom_range(4095));
		c.y = 12'($urandom_range(4095));
		c.ul = 1'($urandom_range(1));
		font_known[addr % StoreBytes] = 1'b1;
		pending_items.push_back(c);
		items_made++;
	endtask

	// Loads every font byte the glyph rows may touch that was never written, then the draw.
	task automatic queue_draw(logic [7:0] code, int x, int y, logic ul);
		int w, h, s, b, i, k;
		glyph_cmd_t c;
		w = clamp_size(gw_reg);
		h = clamp_size(gh_reg);
		for (i = 0; i <= h; i++) begin
			s = int'(code) * w * h + i * w;
			for (k = 0; k < 2; k++) begin
				b = ((s >> 3) + k) % StoreBytes;
				if (!font_known[b])
					queue_load(b, $urandom_range(255));
			end
		end
		c.op = OP_DRAW;
		c.addr = 11'($urandom_range(StoreBytes - 1));
		c.fbyte = 8'($urandom_range(255));
		c.code = code;
		c.x = x[11:0];
		c.y = y[11:0];
		c.ul = ul;
		pending_items.push_back(c);
		items_made++;
	endtask

	task automatic set_reg(cfg_reg_t idx, int val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CfgDataW-1:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			CFG_CLIP_LEFT: clip_l = val;
			CFG_CLIP_TOP: clip_t = val;
			CFG_CLIP_RIGHT: clip_r = val;
			CFG_CLIP_BOTTOM: clip_b = val;
			CFG_LINE_PITCH: pitch = val;
			CFG_DRAW_COLOR: ink = val;
			CFG_GLYPH_WIDTH: gw_reg = val[3:0];
			CFG_GLYPH_HEIGHT: gh_reg = val[3:0];
			default: ;
		endcase
	endtask

	// Waits until every item is in and every row write is out, then lets the block settle.
	task automatic wait_idle();
		while (pending_items.size() != 0 || in_valid || glyph_rows_q.size() != 0)
			@(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	// Input driver: predicts each accepted item and offers the next one.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				render_glyph(on_wire);
			if (!in_valid || !in_stall) begin
				if (pending_items.size() != 0 && !sender_hold &&
						$urandom_range(99) >= idle_pct) begin
					on_wire <= pending_items.pop_front();
					in_valid <= 1'b1;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// Output stall: random, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_ask) begin
			hold_seen <= hold_ask;
			hold_left <= hold_len;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Output monitor: each accepted row write is checked against the oldest expectation.
	always @(posedge clk) begin : check_rows
		row_write_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (glyph_rows_q.size() == 0)
				note_mismatch("row write with none pending", 32'(row_address), 32'(0));
			else begin
				want = glyph_rows_q.pop_front();
				if (row_address !== want.addr)
					note_mismatch("row_address", 32'(row_address), 32'(want.addr));
				if (write_mask !== want.mask)
					note_mismatch("write_mask", 32'(write_mask), 32'(want.mask));
				if (color !== want.color)
					note_mismatch("color", 32'(color), 32'(want.color));
				if (last !== want.last)
					note_mismatch("last", 32'(last), 32'(want.last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("tb_clipped_glyph_row_renderer_top failed");
			$finish;
		end
	end

	initial begin : run_phases
		int phase, n, k, r, w, h, x, y, sx, sy;
		int ncl, nct, ncr, ncb, npitch, ncolor, nw, nh;
		logic [7:0] pool [4];
		logic [7:0] code;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed items under the reset setup: 640 x 480 box, 8 x 8 glyphs.
		queue_load(0, 8'h00);
		queue_load(StoreBytes - 1, 8'hFF);
		for (k = StoreBytes - 8; k < StoreBytes - 1; k++)
			queue_load(k, 8'hFF);
		queue_draw(8'd0, 0, 0, 1'b1);
		queue_draw(8'd255, 632, 472, 1'b1);
		queue_draw(8'd0, -2048, -2048, 1'b0);
		queue_draw(8'd255, 2047, 2047, 1'b1);
		queue_draw(8'd255, -8, -4, 1'b1);
		queue_draw(8'd255, 640, 100, 1'b0);
		queue_draw(8'd0, -9, 100, 1'b0);
		queue_draw(8'd0, 100, -9, 1'b1);
		queue_draw(8'd255, 641, 100, 1'b0);
		queue_draw(8'd255, 100, 481, 1'b1);
		queue_draw(8'd255, 636, -2, 1'b1);
		queue_draw(8'd0, -3, 476, 1'b1);
		queue_draw(8'd255, 300, 471, 1'b1);

		phase = 1;
		while (items_made < ItemTarget) begin
			wait_idle();

			// Random setup, with fixed extremes in the early phases.
			ncl = $urandom_range(700);
			nct = $urandom_range(500);
			ncr = ncl + $urandom_range(600);
			ncb = nct + $urandom_range(400);
			if ($urandom_range(5) == 0) begin
				ncl = 2047 - $urandom_range(8);
				ncr = 2048;
			end
			npitch = $urandom_range(4096, 1);
			ncolor = $urandom_range(255);
			nw = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(8, 1);
			nh = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(8, 1);
			case (phase)
				1: begin
					ncl = 0;
					nct = 0;
					ncr = 2048;
					ncb = 2048;
					npitch = 4096;
					ncolor = 255;
					nw = 8;
					nh = 8;
				end
				2: begin
					npitch = 1;
					ncolor = 0;
					nw = 1;
					nh = 1;
				end
				3: begin
					nw = 0;
					nh = 15;
				end
				4: begin
					// Empty box in x, inverted box in y.
					ncl = 300;
					ncr = 300;
					nct = 60;
					ncb = 55;
				end
				default: ;
			endcase
			set_reg(CFG_CLIP_LEFT, ncl);
			set_reg(CFG_CLIP_TOP, nct);
			set_reg(CFG_CLIP_RIGHT, ncr);
			set_reg(CFG_CLIP_BOTTOM, ncb);
			set_reg(CFG_LINE_PITCH, npitch);
			set_reg(CFG_DRAW_COLOR, ncolor);
			set_reg(CFG_GLYPH_WIDTH, nw);
			set_reg(CFG_GLYPH_HEIGHT, nh);
			@(negedge clk);

			case (phase % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 63;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 63;
				end
				default: begin
					idle_pct = 10;
					stall_pct = 10;
				end
			endcase

			// Hold the output off long enough for the block to back up into its input.
			if (phase == 4) begin
				hold_len = 250;
				hold_ask++;
			end

			for (k = 0; k < 4; k++)
				pool[k] = 8'($urandom_range(255));
			n = 36 + $urandom_range(12);
			for (k = 0; k < n; k++) begin
				// Midway through one phase the sender waits for every row write.
				if (phase == 5 && k == n / 2) begin
					while (pending_items.size() != 0)
						@(negedge clk);
					sender_hold = 1'b1;
					while (in_valid || glyph_rows_q.size() != 0)
						@(negedge clk);
					sender_hold = 1'b0;
				end
				r = $urandom_range(99);
				if (r < 8)
					queue_load($urandom_range(StoreBytes - 1), $urandom_range(255));
				else begin
					code = (r < 85) ? pool[$urandom_range(3)] : 8'($urandom_range(255));
					w = clamp_size(gw_reg);
					h = clamp_size(gh_reg);
					if ($urandom_range(4) == 0) begin
						x = int'($urandom_range(4095)) - 2048;
						y = int'($urandom_range(4095)) - 2048;
					end else begin
						// Positions around the clip box, straddling its left, right, top and bottom edges.
						sx = clip_r - clip_l + w + 6;
						sy = clip_b - clip_t + h + 6;
						if (sx < 1)
							sx = 1;
						if (sy < 1)
							sy = 1;
						x = clip_l - w - 3 + int'($urandom_range(sx - 1));
						y = clip_t - h - 3 + int'($urandom_range(sy - 1));
					end
					queue_draw(code, x, y, 1'($urandom_range(1)));
				end
			end
			phase++;
		end

		wait_idle();
		if (err_count == 0)
			$display("tb_clipped_glyph_row_renderer_top passed");
		else
			$display("tb_clipped_glyph_row_renderer_top failed");
		$finish;
	end

endmodule
